// ----- hdl/page_count_quantized_pack_macros.svh -----
// Assertion macros for the page count packer.
// Included by the top level; relies on clk and rst_n in the including module.
`ifndef PAGE_COUNT_QUANTIZED_PACK_MACROS_SVH
`define PAGE_COUNT_QUANTIZED_PACK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCQP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCQP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pcqp_pkg.sv -----
// Types and constants of the page count packer.
// Used by page_count_quantized_pack; depends on nothing else.
package pcqp_pkg;

  typedef logic [31:0] value_t;
  typedef logic [26:0] result_t;
  typedef logic [15:0] code_t;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  localparam logic [31:0] EXACT_LIMIT   = 32'd32769;
  localparam logic [31:0] EVEN_LIMIT    = 32'd65536;
  localparam logic [31:0] SAT_LIMIT     = 32'd67108864;
  localparam code_t       ALL_ONES      = 16'hFFFF;
  localparam result_t     BASE_PAGES    = 27'd32768;
  localparam result_t     ALL_ONES_PAGES = 27'd65536;
  localparam result_t     SAT_CODE      = 27'd65533;
  localparam logic [3:0]  SHIFT_BIAS    = 4'd8;
  localparam int          EXP_BASE_BIT  = 19;

endpackage

// ----- hdl/page_count_quantized_pack.sv -----
// Page count packer: converts a page count to the 16-bit quantized code or back.
// Registered in stages 1, 2 and 3; one item per cycle while out_stall is low.
// Stage 1 classifies, stage 2 picks the exponent or shifts the decode mantissa,
// stage 3 forms the code or the page count. Each stage stalls only when full
// and blocked downstream. Reset (rst_n, synchronous, active low) empties the
// pipeline; payload registers are not reset.
`include "page_count_quantized_pack_macros.svh"

module page_count_quantized_pack (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  pcqp_pkg::value_t  in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output pcqp_pkg::result_t out_result
);
  import pcqp_pkg::*;

  // Stage 1 registers.
  logic        v1_r, act1_r, pass1_r, all1_r, sat1_r;
  code_t       pval1_r;
  logic [25:0] d1_1_r;
  logic [11:0] mant1_r;
  logic [2:0]  exp1_r;
  // Stage 2 registers.
  logic        v2_r, act2_r, pass2_r, all2_r, sat2_r;
  code_t       pval2_r;
  logic [25:0] d1_2_r;
  logic [2:0]  e2_r;
  result_t     dsh2_r;
  // Output stage.
  logic        out_valid_r;
  result_t     out_result_r;

  logic rdy1, rdy2, rdy3;
  assign rdy3 = !out_valid_r || !out_stall;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // Stage 1 logic.
  code_t       s1_code;
  logic        s1_tagged, s1_exact, s1_sat;
  logic [31:0] s1_diff;
  assign s1_code   = in_value[15:0];
  assign s1_tagged = s1_code[15] & s1_code[0];
  assign s1_exact  = (in_value < EXACT_LIMIT) || ((in_value < EVEN_LIMIT) && !in_value[0]);
  assign s1_sat    = (in_value >= SAT_LIMIT);
  assign s1_diff   = in_value - EXACT_LIMIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
    if (rdy1) begin
      act1_r  <= in_action;
      pass1_r <= (in_action == ACT_DECODE) ? !s1_tagged : s1_exact;
      all1_r  <= (s1_code == ALL_ONES);
      sat1_r  <= s1_sat;
      pval1_r <= s1_code;
      d1_1_r  <= s1_diff[25:0];
      mant1_r <= {1'b0, s1_code[11:1]} + 12'd1;
      exp1_r  <= s1_code[14:12];
    end
  end

  // Stage 2 logic: smallest exponent whose range holds the offset count, and the decode mantissa shift amount.
  logic [2:0] s2_e;
  logic [3:0] s2_shamt;
  always_comb begin
    s2_e = 3'd7;
    for (int e = 6; e >= 0; e--) begin
      if ((d1_1_r >> (EXP_BASE_BIT + e)) == 26'd0) begin
        s2_e = 3'(e);
      end
    end
  end
  assign s2_shamt = {1'b0, exp1_r} + SHIFT_BIAS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2) begin
      act2_r  <= act1_r;
      pass2_r <= pass1_r;
      all2_r  <= all1_r;
      sat2_r  <= sat1_r;
      pval2_r <= pval1_r;
      d1_2_r  <= d1_1_r;
      e2_r    <= s2_e;
      dsh2_r  <= {15'd0, mant1_r} << s2_shamt;
    end
  end

  // Stage 3 logic: the mantissa is the offset count shifted down, rounding up
  // being folded into the offset of one.
  logic [3:0]  s3_shamt;
  logic [25:0] s3_shifted;
  code_t       s3_code;
  result_t     s3_result;
  assign s3_shamt   = {1'b0, e2_r} + SHIFT_BIAS;
  assign s3_shifted = d1_2_r >> s3_shamt;
  assign s3_code    = {1'b1, e2_r, s3_shifted[10:0], 1'b1};

  always_comb begin
    if (pass2_r) begin
      s3_result = {11'd0, pval2_r};
    end else if (act2_r == ACT_DECODE) begin
      s3_result = all2_r ? ALL_ONES_PAGES : (BASE_PAGES + dsh2_r);
    end else begin
      s3_result = sat2_r ? SAT_CODE : {11'd0, s3_code};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy3) begin
      out_valid_r <= v2_r;
    end
    if (rdy3) begin
      out_result_r <= s3_result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  `PCQP_ASSERT_NOW(a_stall_full, in_stall, v1_r && v2_r && out_valid_r && out_stall, "input stalled while pipeline has room")
  `PCQP_ASSERT_NEXT(a_s2_to_out, v2_r && rdy3, out_valid_r, "item lost between stage 2 and output")
  `PCQP_ASSERT_NOW(a_mant_fits, v2_r && (act2_r == ACT_ENCODE) && !pass2_r && !sat2_r, (d1_2_r >> (5'd19 + {2'b00, e2_r})) == 26'd0, "encode mantissa exceeds 11 bits")

endmodule
